/* design/assert_macros.svh */
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define ABA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is asserted
`define ABA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/aba_pkg.sv */
`timescale 1ns / 1ps
package aba_pkg;

    // field widths fixed by the interface
    localparam int SIZE_W  = 17;
    localparam int ALIGN_W = 17;
    localparam int OFF_W   = 16;
    localparam int ORD_W   = 5;
    localparam int CFG_W   = 5;
    localparam int GRP_W   = 8;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_UNKNOWN  = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_PREP_A,
        S_PREP_B,
        S_CHECK,
        S_SLOT,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SPLIT_CLR,
        S_SPLIT,
        S_DIV,
        S_USED_WR,
        S_FSCAN,
        S_MRG_RD,
        S_MRG_CHK,
        S_MRG_SET,
        S_RESULT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic    clr_step;
        logic    load;
        logic    prep_a;
        logic    prep_b;
        logic    slot_step;
        logic    scan_chk;
        logic    split_init;
        logic    split_step;
        logic    div_init;
        logic    div_step;
        logic    used_wr;
        logic    fscan_step;
        logic    mrg_rd;
        logic    mrg_join;
        logic    mrg_set;
        logic    res_load;
        t_status res_code;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic is_free;
        logic too_big;
        logic full;
        logic slot_hit;
        logic scan_last;
        logic scan_any;
        logic split_done;
        logic div_last;
        logic fmatch;
        logic fend;
        logic mrg_top;
        logic mrg_match;
    } t_sts;

endpackage

/* design/aba_ram.sv */
`timescale 1ns / 1ps
module aba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/aba_ctrl.sv */
`timescale 1ns / 1ps
module aba_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  aba_pkg::t_sts i_sts,
    output aba_pkg::t_cmd o_cmd
);

    aba_pkg::t_state  r_state, n_state;
    aba_pkg::t_status r_res, n_res;
    logic             r_out_valid, n_out_valid;
    aba_pkg::t_cmd    w_cmd;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= aba_pkg::S_CLEAR;
            r_res       <= aba_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res       <= n_res;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_res   = r_res;
        w_cmd   = '0;
        w_cmd.res_code = r_res;
        case (r_state)
            aba_pkg::S_CLEAR: begin
                if (i_sts.clr_done) n_state = aba_pkg::S_IDLE;
                else w_cmd.clr_step = 1'b1;
            end
            aba_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    n_state    = aba_pkg::S_PREP_A;
                end
            end
            aba_pkg::S_PREP_A: begin
                if (i_sts.is_free) begin
                    n_state = aba_pkg::S_FSCAN;
                end else begin
                    w_cmd.prep_a = 1'b1;
                    n_state      = aba_pkg::S_PREP_B;
                end
            end
            aba_pkg::S_PREP_B: begin
                w_cmd.prep_b = 1'b1;
                n_state      = aba_pkg::S_CHECK;
            end
            aba_pkg::S_CHECK: begin
                if (i_sts.too_big) begin
                    n_res   = aba_pkg::ST_NO_SPACE;
                    n_state = aba_pkg::S_RESULT;
                end else if (i_sts.full) begin
                    n_res   = aba_pkg::ST_FULL;
                    n_state = aba_pkg::S_RESULT;
                end else begin
                    n_state = aba_pkg::S_SLOT;
                end
            end
            aba_pkg::S_SLOT: begin
                w_cmd.slot_step = 1'b1;
                if (i_sts.slot_hit) n_state = aba_pkg::S_SCAN_RD;
            end
            aba_pkg::S_SCAN_RD: begin
                n_state = aba_pkg::S_SCAN_CHK;
            end
            aba_pkg::S_SCAN_CHK: begin
                w_cmd.scan_chk = 1'b1;
                if (!i_sts.scan_last) begin
                    n_state = aba_pkg::S_SCAN_RD;
                end else if (i_sts.scan_any) begin
                    n_state = aba_pkg::S_SPLIT_CLR;
                end else begin
                    n_res   = aba_pkg::ST_NO_SPACE;
                    n_state = aba_pkg::S_RESULT;
                end
            end
            aba_pkg::S_SPLIT_CLR: begin
                w_cmd.split_init = 1'b1;
                n_state          = aba_pkg::S_SPLIT;
            end
            aba_pkg::S_SPLIT: begin
                if (i_sts.split_done) begin
                    w_cmd.div_init = 1'b1;
                    n_state        = aba_pkg::S_DIV;
                end else begin
                    w_cmd.split_step = 1'b1;
                end
            end
            aba_pkg::S_DIV: begin
                w_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = aba_pkg::S_USED_WR;
            end
            aba_pkg::S_USED_WR: begin
                w_cmd.used_wr = 1'b1;
                n_res         = aba_pkg::ST_OK;
                n_state       = aba_pkg::S_RESULT;
            end
            aba_pkg::S_FSCAN: begin
                w_cmd.fscan_step = 1'b1;
                if (i_sts.fmatch) begin
                    n_state = aba_pkg::S_MRG_RD;
                end else if (i_sts.fend) begin
                    n_res   = aba_pkg::ST_UNKNOWN;
                    n_state = aba_pkg::S_RESULT;
                end
            end
            aba_pkg::S_MRG_RD: begin
                if (i_sts.mrg_top) begin
                    n_state = aba_pkg::S_MRG_SET;
                end else begin
                    w_cmd.mrg_rd = 1'b1;
                    n_state      = aba_pkg::S_MRG_CHK;
                end
            end
            aba_pkg::S_MRG_CHK: begin
                if (i_sts.mrg_match) begin
                    w_cmd.mrg_join = 1'b1;
                    n_state        = aba_pkg::S_MRG_RD;
                end else begin
                    n_state = aba_pkg::S_MRG_SET;
                end
            end
            aba_pkg::S_MRG_SET: begin
                w_cmd.mrg_set = 1'b1;
                n_res         = aba_pkg::ST_OK;
                n_state       = aba_pkg::S_RESULT;
            end
            aba_pkg::S_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    w_cmd.res_load = 1'b1;
                    n_state        = aba_pkg::S_IDLE;
                end
            end
            default: n_state = aba_pkg::S_IDLE;
        endcase
    end

    // output word valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;
        if (w_cmd.res_load) n_out_valid = 1'b1;
    end

    assign o_cmd       = w_cmd;
    assign o_in_ready  = (r_state == aba_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* design/aba_dpath.sv */
`timescale 1ns / 1ps
module aba_dpath #(
    parameter int ARENA_LOG2   = 16,
    parameter int UNIT_LOG2    = 4,
    parameter int USED_ENTRIES = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [aba_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic                        i_cmd,
    input  logic [aba_pkg::SIZE_W-1:0]  i_req_size,
    input  logic [aba_pkg::ALIGN_W-1:0] i_req_alignment,
    input  logic [aba_pkg::OFF_W-1:0]   i_free_offset,
    input  aba_pkg::t_cmd               i_ctl,
    output aba_pkg::t_sts               o_sts,
    output logic [1:0]                  o_status,
    output logic [aba_pkg::OFF_W-1:0]   o_alloc_offset,
    output logic [aba_pkg::ORD_W-1:0]   o_block_order
);

    localparam int NU_W      = ARENA_LOG2 - UNIT_LOG2;
    localparam int NUM_UNITS = 1 << NU_W;
    localparam int UA_W      = (NU_W > 0) ? NU_W : 1;
    localparam int UC_W      = UA_W + 1;
    localparam int AOFF_W    = ((ARENA_LOG2 > aba_pkg::ALIGN_W) ? ARENA_LOG2
                                                                : aba_pkg::ALIGN_W) + 1;
    localparam int SL_W      = $clog2(USED_ENTRIES);
    localparam int NV_W      = $clog2(USED_ENTRIES + 1);
    localparam int NG        = (USED_ENTRIES + aba_pkg::GRP_W - 1) / aba_pkg::GRP_W;
    localparam int GI_W      = (NG > 1) ? $clog2(NG) : 1;
    localparam int PAD       = NG * aba_pkg::GRP_W;
    localparam int GP_W      = $clog2(aba_pkg::GRP_W);
    localparam int OW        = aba_pkg::ORD_W;
    localparam int USED_W    = AOFF_W + UA_W + OW;
    localparam int DC_W      = $clog2(ARENA_LOG2);
    localparam int NEED_W    = aba_pkg::SIZE_W + 1;

    // highest set bit of a narrow word
    function automatic logic [OW-1:0] flog2(input logic [NEED_W-1:0] v);
        logic [OW-1:0] r;
        r = '0;
        for (int i = 0; i < NEED_W; i++) begin
            if (v[i]) r = OW'(i);
        end
        return r;
    endfunction

    // configuration
    logic [aba_pkg::CFG_W-1:0] r_cfg;

    // request
    logic                        r_is_free;
    logic [aba_pkg::SIZE_W-1:0]  r_size;
    logic [aba_pkg::ALIGN_W-1:0] r_align;
    logic [aba_pkg::OFF_W-1:0]   r_foff;

    // sizing
    logic [OW-1:0]     r_fl, r_k, r_slog;
    logic [NEED_W-1:0] r_need;
    logic              r_too_big;

    // used table bookkeeping
    logic [USED_ENTRIES-1:0] r_valid;
    logic [NV_W-1:0]         r_nvalid;
    logic [GI_W-1:0]         r_grp;
    logic [SL_W-1:0]         r_slot;
    logic [NV_W-1:0]         r_fi;
    logic [SL_W-1:0]         r_pidx;
    logic                    r_pv;

    // free map scan, split, merge
    logic [UC_W-1:0] r_u, r_clr;
    logic [UA_W-1:0] r_best_u, r_addr_u;
    logic [OW-1:0]   r_best_o, r_o, r_ord;
    logic            r_found;

    // offset rounding
    logic [aba_pkg::ALIGN_W-1:0] r_rem;
    logic [DC_W-1:0]             r_dcnt;
    logic [AOFF_W-1:0]           r_off;

    // result word
    logic [1:0]                r_st;
    logic [aba_pkg::OFF_W-1:0] r_oo;
    logic [OW-1:0]             r_ob;

    // memories
    logic              w_fwe;
    logic [UA_W-1:0]   w_fwaddr, w_fraddr;
    logic [OW-1:0]     w_fwdata, w_frd;
    logic [USED_W-1:0] w_uwdata, w_urd;

    aba_ram #(.WIDTH(OW), .DEPTH(NUM_UNITS)) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (w_fwe),
        .i_waddr (w_fwaddr),
        .i_wdata (w_fwdata),
        .i_raddr (w_fraddr),
        .o_rdata (w_frd)
    );

    aba_ram #(.WIDTH(USED_W), .DEPTH(USED_ENTRIES)) u_used_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.used_wr),
        .i_waddr (r_slot),
        .i_wdata (w_uwdata),
        .i_raddr (r_fi[SL_W-1:0]),
        .o_rdata (w_urd)
    );

    // minimum order, clamped
    logic [OW-1:0] w_minord;
    always_comb begin
        w_minord = r_cfg;
        if (w_minord < OW'(UNIT_LOG2)) w_minord = OW'(UNIT_LOG2);
        if (w_minord > OW'(ARENA_LOG2)) w_minord = OW'(ARENA_LOG2);
    end

    // sizing steps
    logic [OW-1:0]     w_fl, w_clog, w_k, w_mx, w_slog;
    logic [NEED_W-1:0] w_need;
    always_comb begin
        w_fl   = flog2(NEED_W'(r_align));
        w_need = NEED_W'(r_size) + NEED_W'(r_align) - (NEED_W'(1) << w_fl);
        w_clog = (r_need <= NEED_W'(1)) ? '0 : flog2(r_need - NEED_W'(1)) + OW'(1);
        w_k    = (w_clog > w_minord) ? w_clog : w_minord;
        w_mx   = (w_k > r_fl) ? w_k : r_fl;
        w_slog = w_mx - OW'(UNIT_LOG2);
        if (w_slog > OW'(NU_W)) w_slog = OW'(NU_W);
    end

    // slot search, one group of valid bits a cycle
    logic [PAD-1:0]           w_vpad;
    logic [aba_pkg::GRP_W-1:0] w_gbits;
    logic [GP_W-1:0]          w_gpos;
    logic                     w_slot_hit;
    for (genvar g = 0; g < PAD; g++) begin : g_pad
        if (g < USED_ENTRIES) begin : g_real
            assign w_vpad[g] = r_valid[g];
        end else begin : g_fill
            assign w_vpad[g] = 1'b1;
        end
    end
    always_comb begin
        w_gbits    = w_vpad[r_grp * aba_pkg::GRP_W +: aba_pkg::GRP_W];
        w_slot_hit = (w_gbits != '1);
        w_gpos     = '0;
        for (int i = aba_pkg::GRP_W - 1; i >= 0; i--) begin
            if (!w_gbits[i]) w_gpos = GP_W'(i);
        end
    end

    // free map scan check
    logic            w_nz, w_hit, w_better, w_last;
    logic [OW-1:0]   w_o, w_ou, w_sh;
    logic [UC_W-1:0] w_next_u;
    always_comb begin
        w_nz     = (w_frd != '0);
        w_o      = w_frd - OW'(1);
        w_hit    = w_nz && (w_o >= r_k);
        w_better = w_hit && (!r_found || (w_o < r_best_o));
        w_ou     = w_nz ? (w_o - OW'(UNIT_LOG2)) : '0;
        w_sh     = (w_ou > r_slog) ? w_ou : r_slog;
        if (w_sh > OW'(NU_W)) w_sh = OW'(NU_W);
        w_next_u = r_u + (UC_W'(1) << w_sh);
        w_last   = (w_next_u >= UC_W'(NUM_UNITS)) || (w_hit && (w_o == r_k));
    end

    // split, merge and rounding helpers
    logic [UA_W-1:0]        w_split_a, w_bbit, w_buddy;
    logic [ARENA_LOG2-1:0]  w_baddr;
    logic [NEED_W-1:0]      w_dt;
    logic [AOFF_W-1:0]      w_off;
    always_comb begin
        w_split_a = r_addr_u + (UA_W'(1) << (r_o - OW'(1) - OW'(UNIT_LOG2)));
        w_bbit    = UA_W'(1) << (r_k - OW'(UNIT_LOG2));
        w_buddy   = r_addr_u ^ w_bbit;
        w_baddr   = ARENA_LOG2'(r_addr_u) << UNIT_LOG2;
        w_dt      = {r_rem, w_baddr[r_dcnt]};
        if (w_dt >= NEED_W'(r_align)) w_dt = w_dt - NEED_W'(r_align);
        w_off     = (r_rem == '0) ? AOFF_W'(w_baddr)
                                  : AOFF_W'(w_baddr) + AOFF_W'(r_align) - AOFF_W'(r_rem);
        w_uwdata  = {w_off, r_addr_u, r_k};
    end

    // used table read check
    logic              w_fmatch;
    logic [AOFF_W-1:0] w_uoff;
    logic [UA_W-1:0]   w_uaddr;
    logic [OW-1:0]     w_uord;
    always_comb begin
        {w_uoff, w_uaddr, w_uord} = w_urd;
        w_fmatch = r_pv && r_valid[r_pidx] && (w_uoff == AOFF_W'(r_foff));
    end

    // free map port selection
    always_comb begin
        w_fwe    = 1'b0;
        w_fwaddr = r_addr_u;
        w_fwdata = '0;
        if (i_ctl.clr_step) begin
            w_fwe    = 1'b1;
            w_fwaddr = r_clr[UA_W-1:0];
            w_fwdata = (r_clr == '0) ? OW'(ARENA_LOG2 + 1) : '0;
        end else if (i_ctl.split_init) begin
            w_fwe    = 1'b1;
            w_fwaddr = r_best_u;
        end else if (i_ctl.split_step) begin
            w_fwe    = 1'b1;
            w_fwaddr = w_split_a;
            w_fwdata = r_o;
        end else if (i_ctl.mrg_join) begin
            w_fwe    = 1'b1;
            w_fwaddr = w_buddy;
        end else if (i_ctl.mrg_set) begin
            w_fwe    = 1'b1;
            w_fwdata = r_k + OW'(1);
        end
        w_fraddr = i_ctl.mrg_rd ? w_buddy : r_u[UA_W-1:0];
    end

    // control state: config, valid bits, counts, clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg    <= aba_pkg::CFG_W'(4);
            r_valid  <= '0;
            r_nvalid <= '0;
            r_clr    <= '0;
        end else begin
            if (i_cfg_we) r_cfg <= i_cfg_wdata;
            if (i_ctl.clr_step) r_clr <= r_clr + UC_W'(1);
            if (i_ctl.used_wr) begin
                r_valid[r_slot] <= 1'b1;
                r_nvalid        <= r_nvalid + NV_W'(1);
            end else if (i_ctl.fscan_step && w_fmatch) begin
                r_valid[r_pidx] <= 1'b0;
                r_nvalid        <= r_nvalid - NV_W'(1);
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_is_free <= (i_cmd == aba_pkg::CMD_FREE);
            r_size    <= i_req_size;
            r_align   <= (i_req_alignment == '0) ? aba_pkg::ALIGN_W'(1) : i_req_alignment;
            r_foff    <= i_free_offset;
            r_grp     <= '0;
            r_u       <= '0;
            r_found   <= 1'b0;
            r_fi      <= '0;
            r_pv      <= 1'b0;
        end
        if (i_ctl.prep_a) begin
            r_fl   <= w_fl;
            r_need <= w_need;
        end
        if (i_ctl.prep_b) begin
            r_k       <= w_k;
            r_too_big <= (w_k > OW'(ARENA_LOG2));
            r_slog    <= w_slog;
        end
        if (i_ctl.slot_step) begin
            if (w_slot_hit) r_slot <= SL_W'(int'(r_grp) * aba_pkg::GRP_W + int'(w_gpos));
            else r_grp <= r_grp + GI_W'(1);
        end
        if (i_ctl.scan_chk) begin
            r_u <= w_next_u;
            if (w_better) begin
                r_found  <= 1'b1;
                r_best_o <= w_o;
                r_best_u <= r_u[UA_W-1:0];
            end
        end
        if (i_ctl.split_init) begin
            r_o      <= r_best_o;
            r_addr_u <= r_best_u;
        end
        if (i_ctl.split_step) r_o <= r_o - OW'(1);
        if (i_ctl.div_init) begin
            r_rem  <= '0;
            r_dcnt <= DC_W'(ARENA_LOG2 - 1);
        end
        if (i_ctl.div_step) begin
            r_rem  <= w_dt[aba_pkg::ALIGN_W-1:0];
            r_dcnt <= r_dcnt - DC_W'(1);
        end
        if (i_ctl.used_wr) begin
            r_off <= w_off;
            r_ord <= r_k;
        end
        if (i_ctl.fscan_step) begin
            if (r_fi < NV_W'(USED_ENTRIES)) begin
                r_pidx <= r_fi[SL_W-1:0];
                r_pv   <= 1'b1;
                r_fi   <= r_fi + NV_W'(1);
            end else begin
                r_pv <= 1'b0;
            end
            if (w_fmatch) begin
                r_addr_u <= w_uaddr;
                r_k      <= w_uord;
                r_ord    <= w_uord;
            end
        end
        if (i_ctl.mrg_join) begin
            r_addr_u <= r_addr_u & ~w_bbit;
            r_k      <= r_k + OW'(1);
        end
        if (i_ctl.res_load) begin
            r_st <= i_ctl.res_code;
            r_oo <= ((i_ctl.res_code == aba_pkg::ST_OK) && !r_is_free)
                    ? r_off[aba_pkg::OFF_W-1:0] : '0;
            r_ob <= (i_ctl.res_code == aba_pkg::ST_OK) ? r_ord : '0;
        end
    end

    // status to controller
    always_comb begin
        o_sts.clr_done   = (r_clr == UC_W'(NUM_UNITS));
        o_sts.is_free    = r_is_free;
        o_sts.too_big    = r_too_big;
        o_sts.full       = (r_nvalid == NV_W'(USED_ENTRIES));
        o_sts.slot_hit   = w_slot_hit;
        o_sts.scan_last  = w_last;
        o_sts.scan_any   = r_found || w_hit;
        o_sts.split_done = (r_o == r_k);
        o_sts.div_last   = (r_dcnt == '0);
        o_sts.fmatch     = w_fmatch;
        o_sts.fend       = !r_pv && (r_fi == NV_W'(USED_ENTRIES));
        o_sts.mrg_top    = (r_k == OW'(ARENA_LOG2));
        o_sts.mrg_match  = (w_frd == r_k + OW'(1));
    end

    assign o_status       = r_st;
    assign o_alloc_offset = r_oo;
    assign o_block_order  = r_ob;

endmodule

/* design/aligned_buddy_allocator.sv */
`timescale 1ns / 1ps
// Buddy allocator over an arena of 2^ARENA_LOG2 bytes kept in units of 2^UNIT_LOG2 bytes,
// one request at a time. After reset a clearing pass over all 2^(ARENA_LOG2-UNIT_LOG2) units
// sweeps the free map memory; requests wait, config writes do not. An allocate searches
// the used table group by group of eight entries for the lowest free slot, then reads and
// checks the free-map units it visits (the scan strides by the block size and alignment
// and skips over free blocks, stopping on an exact fit), then splits one level at a time.
// A free walks the used table at one entry a cycle to the first match, then reads and checks
// the buddy for each merge level. The free map memory and the used table memory each have
// one write port and a registered read port. A result word waits in an output register;
// the next request is taken while it waits.
module aligned_buddy_allocator #(
    parameter int ARENA_LOG2   = 16,
    parameter int UNIT_LOG2    = 4,
    parameter int USED_ENTRIES = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [aba_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_cmd,
    input  logic [aba_pkg::SIZE_W-1:0]  i_req_size,
    input  logic [aba_pkg::ALIGN_W-1:0] i_req_alignment,
    input  logic [aba_pkg::OFF_W-1:0]   i_free_offset,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [1:0]                  o_status,
    output logic [aba_pkg::OFF_W-1:0]   o_alloc_offset,
    output logic [aba_pkg::ORD_W-1:0]   o_block_order
);

    aba_pkg::t_cmd w_cmd;
    aba_pkg::t_sts w_sts;

    // sequencer
    aba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // free map, used table and arithmetic
    aba_dpath #(
        .ARENA_LOG2   (ARENA_LOG2),
        .UNIT_LOG2    (UNIT_LOG2),
        .USED_ENTRIES (USED_ENTRIES)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_cmd           (i_cmd),
        .i_req_size      (i_req_size),
        .i_req_alignment (i_req_alignment),
        .i_free_offset   (i_free_offset),
        .i_ctl           (w_cmd),
        .o_sts           (w_sts),
        .o_status        (o_status),
        .o_alloc_offset  (o_alloc_offset),
        .o_block_order   (o_block_order)
    );

endmodule

/* design/aba_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module aba_checker #(
    parameter int ARENA_LOG2 = 16
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [1:0]                  o_status,
    input logic [aba_pkg::OFF_W-1:0]   o_alloc_offset,
    input logic [aba_pkg::ORD_W-1:0]   o_block_order
);

    // a stalled result word holds
    `ABA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_status) && $stable(o_alloc_offset) && $stable(o_block_order), "result word changed while stalled")

    // a failed request carries no offset and no order
    `ABA_ASSERT_IMP(a_fail_zero, i_clk, i_rst_n, o_out_valid && (o_status != aba_pkg::ST_OK), (o_alloc_offset == '0) && (o_block_order == '0), "failed request with nonzero fields")

    // one request at a time
    `ABA_ASSERT_NXT(a_busy, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "request taken while busy")

    // block order never beyond the arena
    `ABA_ASSERT_IMP(a_order_range, i_clk, i_rst_n, o_out_valid, o_block_order <= aba_pkg::ORD_W'(ARENA_LOG2), "block order beyond arena")

endmodule

bind aligned_buddy_allocator aba_checker #(.ARENA_LOG2(ARENA_LOG2)) u_aba_checker (.*);
